// ===== hdl/adc_cal_pkg.sv =====
// ----------------------------------------------------------------------------
// adc_cal_pkg
// Shared constants, codes and widths for the two-point ADC calibrator.
// ----------------------------------------------------------------------------
package adc_cal_pkg;

  // Block sizing
  localparam int NUM_BOARDS   = 4;
  localparam int ZERO_SAMPLES = 10;
  localparam int CALIB_PASSES = 200;

  // Board index is a 2-bit field, so four board slots always exist
  localparam int BOARD_W     = 2;
  localparam int BOARD_SLOTS = 1 << BOARD_W;

  localparam int CODE_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int CAL_W    = 64;
  localparam int CNT_W    = $clog2(ZERO_SAMPLES + 1);
  localparam int SUM_W    = CODE_W + CNT_W;
  localparam int PASS_W   = $clog2(CALIB_PASSES + 1);

  localparam logic [CODE_W-1:0] CODE_MAX  = {CODE_W{1'b1}};
  localparam logic [CNT_W-1:0]  ZS_CNT    = CNT_W'(ZERO_SAMPLES);
  localparam logic [PASS_W-1:0] PASS_INIT = PASS_W'(CALIB_PASSES);

  // Zero point average as a reciprocal multiply: for any SUM_W-bit sum,
  // sum / ZERO_SAMPLES equals (sum * ceil(2^S / ZERO_SAMPLES)) >> S
  localparam int ZS_SHIFT   = SUM_W + $clog2(ZERO_SAMPLES);
  localparam int ZS_RECIP_W = SUM_W + 1;
  localparam int ZS_PROD_W  = SUM_W + ZS_RECIP_W;
  localparam logic [ZS_RECIP_W-1:0] ZS_RECIP =
    ZS_RECIP_W'(((64'd1 << ZS_SHIFT) + 64'(ZERO_SAMPLES - 1)) / 64'(ZERO_SAMPLES));

  // Calibration word reset: 24000 mV full scale, everything else zero
  localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(64'd24000 << 32);

  // Shared divider: one quotient bit per cycle
  localparam int DIV_STEPS = VALUE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Transaction kinds
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_PASS   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_PRESET = 2'd3;

  // Channel codes
  localparam logic CH_CURRENT = 1'b0;
  localparam logic CH_VOLTAGE = 1'b1;

endpackage

// ===== hdl/adc_two_point_calibrator.sv =====
// ----------------------------------------------------------------------------
// adc_two_point_calibrator
// Scales raw current/voltage codes of four boards to mA/mV with per-board
// zero points and span words, and runs the zero calibration session.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction contents
//  -------   ---------  ---------------------------------------------------
//  s_axis    in         tuser: op; tdata: board, channel, raw
//  m_axis    out        tdata: value, out_board, out_channel, calibrating,
//                       calib_done, board_zeroed
//  cfg       in         cfg_we / cfg_index / cfg_data, one board word each
//
//  A sample passes through the accepting state, a prepare state (which also
//  writes both zero point averages when the sample completes a board), a
//  multiply state, the shared restoring divider and an output state. A sample
//  whose span is not positive, or a voltage code at or below its zero point,
//  skips multiply and divide. Other operations go from accept to output.
//  rst is synchronous and clears the sequencer, session and per-board
//  calibration state; calibration words go to reset. s_axis_tready is high
//  only while the sequencer is idle; an untaken result holds the output state.
//
module adc_two_point_calibrator (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] board, [2] channel, [18:3] raw, zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] out_board,
                                      // [34] out_channel, [35] calibrating,
                                      // [36] calib_done, [37] board_zeroed
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Calibration words and calibration state
  logic [adc_cal_pkg::CAL_W-1:0]  cal_word      [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::CODE_W-1:0] zero_current  [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::CODE_W-1:0] zero_voltage  [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::SUM_W-1:0]  sum_current   [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::SUM_W-1:0]  sum_voltage   [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::CNT_W-1:0]  count_current [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::CNT_W-1:0]  count_voltage [adc_cal_pkg::BOARD_SLOTS];
  logic [adc_cal_pkg::BOARD_SLOTS-1:0] board_done;
  logic                           session_active;
  logic                           session_finished;
  logic [adc_cal_pkg::PASS_W-1:0] passes_left;

  // Sequencer and item registers
  logic [2:0]                        state;
  logic [adc_cal_pkg::BOARD_W-1:0]   it_board;
  logic                              it_ch;
  logic [adc_cal_pkg::CODE_W-1:0]    it_raw;
  logic [adc_cal_pkg::CODE_W-1:0]    op_r0;
  logic [adc_cal_pkg::CODE_W-1:0]    op_rs;
  logic [adc_cal_pkg::CODE_W-1:0]    op_fs;
  logic [adc_cal_pkg::CODE_W-1:0]    op_d;
  logic [adc_cal_pkg::CODE_W-1:0]    op_den;
  logic                              zeroing;
  logic [adc_cal_pkg::VALUE_W-1:0]   value_q;

  // Shared divider registers
  logic [adc_cal_pkg::VALUE_W-1:0]   div_quo;
  logic [adc_cal_pkg::CODE_W-1:0]    div_rem;
  logic [adc_cal_pkg::CODE_W-1:0]    div_den;
  logic [adc_cal_pkg::DIV_CNT_W-1:0] div_cnt;

  // Output register
  logic        out_valid;
  logic [39:0] out_data;
  logic        out_load;

  // Input field unpacking
  logic [1:0]                      in_op;
  logic [adc_cal_pkg::BOARD_W-1:0] in_board;
  logic                            in_ch;
  logic [adc_cal_pkg::CODE_W-1:0]  in_raw;
  logic                            in_accept;
  logic                            in_valid_board;

  assign in_op          = s_axis_tuser[1:0];
  assign in_board       = s_axis_tdata[1:0];
  assign in_ch          = s_axis_tdata[2];
  assign in_raw         = s_axis_tdata[18:3];
  assign s_axis_tready  = (state == S_IDLE);
  assign in_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_board = (32'(in_board) < adc_cal_pkg::NUM_BOARDS);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_load      = (state == S_OUT) && (!out_valid || m_axis_tready);

  // Average of ZERO_SAMPLES accumulated codes
  function automatic logic [adc_cal_pkg::CODE_W-1:0] zero_average(
      input logic [adc_cal_pkg::SUM_W-1:0] acc);
    logic [adc_cal_pkg::ZS_PROD_W-1:0] prod;
    prod = adc_cal_pkg::ZS_PROD_W'(acc) * adc_cal_pkg::ZS_PROD_W'(adc_cal_pkg::ZS_RECIP);
    return prod[adc_cal_pkg::ZS_SHIFT +: adc_cal_pkg::CODE_W];
  endfunction

  // Zero-calibration accumulation for an incoming sample
  logic                           good;
  logic                           take_c;
  logic                           take_v;
  logic [adc_cal_pkg::CNT_W-1:0]  cc_new;
  logic [adc_cal_pkg::CNT_W-1:0]  cv_new;
  logic                           zero_now;

  always_comb begin
    good   = (in_raw != '0) && (in_raw != adc_cal_pkg::CODE_MAX);
    take_c = session_active && (in_ch == adc_cal_pkg::CH_CURRENT) &&
             (count_current[in_board] < adc_cal_pkg::ZS_CNT) && good;
    take_v = session_active && (in_ch == adc_cal_pkg::CH_VOLTAGE) &&
             (count_voltage[in_board] < adc_cal_pkg::ZS_CNT) && good;
    cc_new = count_current[in_board] + adc_cal_pkg::CNT_W'(take_c);
    cv_new = count_voltage[in_board] + adc_cal_pkg::CNT_W'(take_v);
    zero_now = session_active && !board_done[in_board] &&
               (cc_new >= adc_cal_pkg::ZS_CNT) && (cv_new >= adc_cal_pkg::ZS_CNT);
  end

  // Operand preparation: distance from zero point and span width
  logic [adc_cal_pkg::CODE_W-1:0] prep_d;
  logic [adc_cal_pkg::CODE_W-1:0] prep_den;
  logic                           prep_skip;

  always_comb begin
    prep_den = op_rs - op_r0;
    if (it_ch == adc_cal_pkg::CH_CURRENT) begin
      prep_d    = (it_raw >= op_r0) ? (it_raw - op_r0) : (op_r0 - it_raw);
      prep_skip = (op_rs <= op_r0);
    end else begin
      prep_d    = (it_raw > op_r0) ? (it_raw - op_r0) : '0;
      prep_skip = (op_rs <= op_r0) || (it_raw <= op_r0);
    end
  end

  // One restoring divide step
  logic [adc_cal_pkg::CODE_W:0]    div_trial;
  logic                            div_fit;
  logic [adc_cal_pkg::CODE_W-1:0]  rem_step;
  logic [adc_cal_pkg::VALUE_W-1:0] quo_step;
  logic                            div_last;

  always_comb begin
    div_trial = {div_rem, div_quo[adc_cal_pkg::VALUE_W-1]};
    div_fit   = (div_trial >= {1'b0, div_den});
    rem_step  = div_fit ? adc_cal_pkg::CODE_W'(div_trial - {1'b0, div_den})
                        : div_trial[adc_cal_pkg::CODE_W-1:0];
    quo_step  = {div_quo[adc_cal_pkg::VALUE_W-2:0], div_fit};
    div_last  = (div_cnt == adc_cal_pkg::DIV_CNT_W'(adc_cal_pkg::DIV_STEPS - 1));
  end

  // Sequencer, calibration state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      session_active   <= 1'b0;
      session_finished <= 1'b0;
      passes_left      <= '0;
      board_done       <= '0;
      zeroing          <= 1'b0;
      for (int i = 0; i < adc_cal_pkg::BOARD_SLOTS; i++) begin
        cal_word[i]      <= adc_cal_pkg::CAL_RESET;
        zero_current[i]  <= '0;
        zero_voltage[i]  <= '0;
        sum_current[i]   <= '0;
        sum_voltage[i]   <= '0;
        count_current[i] <= '0;
        count_voltage[i] <= '0;
      end
    end else begin
      // Configuration writes
      if (cfg_we) begin
        cal_word[cfg_index] <= cfg_data;
      end

      // Output handshake
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            it_board <= in_board;
            it_ch    <= in_ch;
            it_raw   <= in_raw;
            value_q  <= '0;
            zeroing  <= (in_op == adc_cal_pkg::OP_SAMPLE) && in_valid_board && zero_now;
            state    <= ((in_op == adc_cal_pkg::OP_SAMPLE) && in_valid_board) ? S_PREP
                                                                               : S_OUT;
            case (in_op)
              adc_cal_pkg::OP_SAMPLE: begin
                if (in_valid_board) begin
                  if (take_c) begin
                    sum_current[in_board] <= sum_current[in_board] +
                                             adc_cal_pkg::SUM_W'(in_raw);
                  end
                  if (take_v) begin
                    sum_voltage[in_board] <= sum_voltage[in_board] +
                                             adc_cal_pkg::SUM_W'(in_raw);
                  end
                  count_current[in_board] <= cc_new;
                  count_voltage[in_board] <= cv_new;
                  if (zero_now) begin
                    board_done[in_board] <= 1'b1;
                  end
                  // Operands use the zero points held before this sample
                  if (in_ch == adc_cal_pkg::CH_CURRENT) begin
                    op_r0 <= zero_current[in_board];
                    op_rs <= cal_word[in_board][31:16];
                    op_fs <= cal_word[in_board][63:48];
                  end else begin
                    op_r0 <= zero_voltage[in_board];
                    op_rs <= cal_word[in_board][15:0];
                    op_fs <= cal_word[in_board][47:32];
                  end
                end
              end
              adc_cal_pkg::OP_PASS: begin
                if (session_active) begin
                  if (passes_left != '0) begin
                    passes_left <= passes_left - 1'b1;
                  end else begin
                    session_active   <= 1'b0;
                    session_finished <= 1'b1;
                  end
                end
              end
              adc_cal_pkg::OP_START: begin
                if (!session_active) begin
                  for (int i = 0; i < adc_cal_pkg::BOARD_SLOTS; i++) begin
                    sum_current[i]   <= '0;
                    sum_voltage[i]   <= '0;
                    count_current[i] <= '0;
                    count_voltage[i] <= '0;
                  end
                  board_done     <= '0;
                  passes_left    <= adc_cal_pkg::PASS_INIT;
                  session_active <= 1'b1;
                end
                session_finished <= 1'b0;
              end
              default: begin
                // Preset of a zero point
                if (in_valid_board) begin
                  if (in_ch == adc_cal_pkg::CH_CURRENT) begin
                    zero_current[in_board] <= in_raw;
                  end else begin
                    zero_voltage[in_board] <= in_raw;
                  end
                end
              end
            endcase
          end
        end

        S_PREP: begin
          op_d   <= prep_d;
          op_den <= prep_den;
          // Operands are already latched, so the new zero points go in now
          if (zeroing) begin
            zero_current[it_board] <= zero_average(sum_current[it_board]);
            zero_voltage[it_board] <= zero_average(sum_voltage[it_board]);
          end
          if (prep_skip) begin
            value_q <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          div_quo <= adc_cal_pkg::VALUE_W'(op_fs) * adc_cal_pkg::VALUE_W'(op_d);
          div_rem <= '0;
          div_den <= op_den;
          div_cnt <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          div_quo <= quo_step;
          div_rem <= rem_step;
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            value_q <= quo_step;
            state   <= S_OUT;
          end
        end

        S_OUT: begin
          // Load the result once the output register is free
          if (out_load) begin
            out_data <= {2'b00, zeroing, session_finished, session_active,
                         it_ch, it_board, value_q};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
